// ===== hdl/owm_pkg.sv =====
// Shared types and constants for the one-wire bus master.
// Holds command codes, configuration indexes, phase encoding and port structs.
// No dependencies.
package owm_pkg;

  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_RESET = 3'd1;
  localparam logic [2:0] OP_WBIT  = 3'd2;
  localparam logic [2:0] OP_RBIT  = 3'd3;
  localparam logic [2:0] OP_WBYTE = 3'd4;
  localparam logic [2:0] OP_RBYTE = 3'd5;

  localparam logic [2:0] CFG_RESET_LOW    = 3'd0;
  localparam logic [2:0] CFG_PRESENCE     = 3'd1;
  localparam logic [2:0] CFG_RESET_REC    = 3'd2;
  localparam logic [2:0] CFG_SLOT_LOW     = 3'd3;
  localparam logic [2:0] CFG_WRITE_SLOT   = 3'd4;
  localparam logic [2:0] CFG_READ_SAMPLE  = 3'd5;
  localparam logic [2:0] CFG_READ_REC     = 3'd6;

  localparam int DUR_WIDTH = 10;

  typedef enum logic [7:0] {
    PH_IDLE     = 8'b0000_0001,
    PH_RST_LOW  = 8'b0000_0010,
    PH_RST_WAIT = 8'b0000_0100,
    PH_RST_REC  = 8'b0000_1000,
    PH_SLOT_LOW = 8'b0001_0000,
    PH_WR_BODY  = 8'b0010_0000,
    PH_RD_WAIT  = 8'b0100_0000,
    PH_RD_REC   = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [9:0] reset_low_time;
    logic [9:0] presence_wait_time;
    logic [9:0] reset_recovery_time;
    logic [3:0] slot_low_time;
    logic [7:0] write_slot_time;
    logic [7:0] read_sample_time;
    logic [7:0] read_recovery_time;
  } cfg_t;

  // Packed so that drive_low lands in bit 0.
  typedef struct packed {
    logic       no_presence;
    logic [7:0] read_data;
    logic       done_res;
    logic       busy_res;
    logic       drive_low;
  } res_t;

endpackage

// ===== hdl/owm_core.sv =====
// Bus timing engine of the one-wire master: phase sequencer, tick counter,
// bit shifter and read/presence result registers. Depends on owm_pkg.
module owm_core #(
  parameter int COUNT_WIDTH = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic [2:0]    operation,
  input  logic [7:0]    write_data,
  input  logic          line_level,
  input  owm_pkg::cfg_t cfg,
  output owm_pkg::res_t res
);
  import owm_pkg::*;

  localparam int LW = (COUNT_WIDTH > DUR_WIDTH) ? COUNT_WIDTH : DUR_WIDTH;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
  localparam logic [LW-1:0] LIM_MAX = LW'(CNT_MAX);

  phase_t                 phase, phase_next;
  logic [COUNT_WIDTH-1:0] tick_count, tick_count_next;
  logic [7:0]             shift_reg, shift_reg_next;
  logic [3:0]             bits_left, bits_left_next;
  logic [2:0]             command_kind;
  logic                   presence_flag, presence_flag_next;
  logic [7:0]             read_value, read_value_next;

  logic                   start;
  phase_t                 ph_eff;
  logic [COUNT_WIDTH-1:0] cnt_eff, cnt_inc;
  logic [7:0]             shift_eff, shift_smp, shift_end;
  logic [3:0]             bits_eff, bits_dec;
  logic [2:0]             kind_eff;
  logic                   is_write;
  logic [DUR_WIDTH-1:0]   dur;
  logic [LW-1:0]          lim;
  logic                   fin;
  logic                   drive, done;

  assign start = (phase == PH_IDLE) && (operation >= OP_RESET) && (operation <= OP_RBYTE);

  always_comb begin
    if (start) begin
      ph_eff   = (operation == OP_RESET) ? PH_RST_LOW : PH_SLOT_LOW;
      cnt_eff  = '0;
      kind_eff = operation;
      if (operation == OP_RESET) begin
        shift_eff = shift_reg;
        bits_eff  = bits_left;
      end else begin
        shift_eff = (operation == OP_RBIT || operation == OP_RBYTE) ? 8'd0 : write_data;
        bits_eff  = (operation == OP_WBYTE || operation == OP_RBYTE) ? 4'd8 : 4'd1;
      end
    end else begin
      ph_eff    = phase;
      cnt_eff   = tick_count;
      kind_eff  = command_kind;
      shift_eff = shift_reg;
      bits_eff  = bits_left;
    end
  end

  assign is_write = (kind_eff == OP_WBIT) || (kind_eff == OP_WBYTE);

  // Duration of the running phase, zero acts as one, clipped to the counter.
  always_comb begin
    unique case (ph_eff)
      PH_RST_LOW:  dur = cfg.reset_low_time;
      PH_RST_WAIT: dur = cfg.presence_wait_time;
      PH_RST_REC:  dur = cfg.reset_recovery_time;
      PH_SLOT_LOW: dur = DUR_WIDTH'(cfg.slot_low_time);
      PH_WR_BODY:  dur = DUR_WIDTH'(cfg.write_slot_time);
      PH_RD_WAIT:  dur = DUR_WIDTH'(cfg.read_sample_time);
      PH_RD_REC:   dur = DUR_WIDTH'(cfg.read_recovery_time);
      default:     dur = '0;
    endcase
  end

  always_comb begin
    lim = (dur == '0) ? LW'(1) : LW'(dur);
    if (lim > LIM_MAX) begin
      lim = LIM_MAX;
    end
  end

  assign cnt_inc  = (cnt_eff == CNT_MAX) ? cnt_eff : cnt_eff + 1'b1;
  assign fin      = LW'(cnt_inc) >= lim;
  assign shift_smp = {line_level, shift_eff[7:1]};
  assign bits_dec = (bits_eff != 4'd0) ? bits_eff - 4'd1 : 4'd0;

  always_comb begin
    phase_next         = ph_eff;
    tick_count_next    = cnt_eff;
    shift_reg_next     = shift_eff;
    bits_left_next     = bits_eff;
    presence_flag_next = presence_flag;
    read_value_next    = read_value;
    drive              = 1'b0;
    done               = 1'b0;
    shift_end          = shift_eff;

    unique case (ph_eff)
      PH_RST_LOW: begin
        drive           = 1'b1;
        tick_count_next = cnt_inc;
        if (fin) begin
          phase_next      = PH_RST_WAIT;
          tick_count_next = '0;
        end
      end
      PH_RST_WAIT: begin
        tick_count_next = cnt_inc;
        if (fin) begin
          presence_flag_next = line_level;
          tick_count_next    = '0;
          if (cfg.reset_recovery_time == '0) begin
            phase_next = PH_IDLE;
            done       = 1'b1;
          end else begin
            phase_next = PH_RST_REC;
          end
        end
      end
      PH_RST_REC: begin
        tick_count_next = cnt_inc;
        if (fin) begin
          phase_next      = PH_IDLE;
          tick_count_next = '0;
          done            = 1'b1;
        end
      end
      PH_SLOT_LOW: begin
        drive           = 1'b1;
        tick_count_next = cnt_inc;
        if (fin) begin
          phase_next      = is_write ? PH_WR_BODY : PH_RD_WAIT;
          tick_count_next = '0;
        end
      end
      PH_WR_BODY, PH_RD_WAIT, PH_RD_REC: begin
        drive           = (ph_eff == PH_WR_BODY) && !shift_eff[0];
        tick_count_next = cnt_inc;
        if (ph_eff == PH_RD_WAIT && fin) begin
          shift_reg_next  = shift_smp;
          shift_end       = shift_smp;
          tick_count_next = '0;
          if (cfg.read_recovery_time != '0) begin
            phase_next = PH_RD_REC;
          end
        end
        // Close the bit slot: write end, read recovery end, or sample with no recovery.
        if (fin && (ph_eff != PH_RD_WAIT || cfg.read_recovery_time == '0)) begin
          if (is_write) begin
            shift_end = {1'b0, shift_eff[7:1]};
          end
          shift_reg_next  = shift_end;
          bits_left_next  = bits_dec;
          tick_count_next = '0;
          if (bits_dec == 4'd0) begin
            if (kind_eff == OP_RBIT) begin
              read_value_next = {7'd0, shift_end[7]};
            end else if (kind_eff == OP_RBYTE) begin
              read_value_next = shift_end;
            end
            phase_next = PH_IDLE;
            done       = 1'b1;
          end else begin
            phase_next = PH_SLOT_LOW;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      tick_count    <= '0;
      shift_reg     <= '0;
      bits_left     <= '0;
      command_kind  <= OP_NONE;
      presence_flag <= 1'b0;
      read_value    <= '0;
    end else if (step) begin
      phase         <= phase_next;
      tick_count    <= tick_count_next;
      shift_reg     <= shift_reg_next;
      bits_left     <= bits_left_next;
      command_kind  <= kind_eff;
      presence_flag <= presence_flag_next;
      read_value    <= read_value_next;
    end
  end

  assign res.drive_low   = drive;
  assign res.busy_res    = (ph_eff != PH_IDLE);
  assign res.done_res    = done;
  assign res.read_data   = read_value_next;
  assign res.no_presence = presence_flag_next;

endmodule

// ===== hdl/onewire_bus_master.sv =====
// One-wire bus master top level: stream handshake, configuration registers
// and output register around owm_core. Depends on owm_pkg and owm_core.
//
// Usage: every transaction on the s_ side is one bus tick (one microsecond).
// s_tdata carries the command code, the byte to write and the sampled line
// level; a command is taken only on a tick where the master is idle, and
// ignored otherwise. Each tick produces exactly one m_ side transaction with
// the line drive, busy, done, last read data and last presence result.
// The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets
// the seven slot timing registers and is always ready. The user must write
// it only with the bus idle (not enforced). An index above six is dropped.
// A tick's result is registered and appears on m_ in the cycle after it.
// Throughput: one tick per cycle unless m_ stalls; each tick update is a pass
// through the core sequencer and counter compare into the output register.
// Reset: sequencer idle, counters and results cleared, timing registers at
// their defaults (480, 100, 380, 1, 60, 14, 45), output register empty.
// Stall: while m_tready is low and a result waits, s_tready drops and the
// sequencer holds; no tick is lost or repeated.
module onewire_bus_master #(
  parameter int COUNT_WIDTH = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [2:0] operation, [10:3] write_data, [11] line_level, [15:12] zero
  input  logic [15:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] drive_low, [1] busy_res, [2] done_res, [10:3] read_data,
  // [11] no_presence, [15:12] zero
  output logic [15:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_data
);
  import owm_pkg::*;

  cfg_t cfg;
  res_t res_now;
  res_t res_q;
  logic step;

  assign s_tready  = !m_tvalid || m_tready;
  assign step      = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_low_time      <= 10'd480;
      cfg.presence_wait_time  <= 10'd100;
      cfg.reset_recovery_time <= 10'd380;
      cfg.slot_low_time       <= 4'd1;
      cfg.write_slot_time     <= 8'd60;
      cfg.read_sample_time    <= 8'd14;
      cfg.read_recovery_time  <= 8'd45;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_RESET_LOW:   cfg.reset_low_time      <= cfg_data;
        CFG_PRESENCE:    cfg.presence_wait_time  <= cfg_data;
        CFG_RESET_REC:   cfg.reset_recovery_time <= cfg_data;
        CFG_SLOT_LOW:    cfg.slot_low_time       <= cfg_data[3:0];
        CFG_WRITE_SLOT:  cfg.write_slot_time     <= cfg_data[7:0];
        CFG_READ_SAMPLE: cfg.read_sample_time    <= cfg_data[7:0];
        CFG_READ_REC:    cfg.read_recovery_time  <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  owm_core #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .operation  (s_tdata[2:0]),
    .write_data (s_tdata[10:3]),
    .line_level (s_tdata[11]),
    .cfg        (cfg),
    .res        (res_now)
  );

  // Hold the result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_q <= res_now;
    end
  end

  assign m_tdata = {4'd0, res_q};

endmodule
